// ----- design/scd_pkg.sv -----
// Shared types, constants and arithmetic helpers for the stereo chorus.
// Used by the configuration registers, the shared multiplier and the top level.
// Has no dependencies of its own.
package scd_pkg;

  // Sample and configuration widths.
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Shared multiplier: signed 17 x 17 so that unsigned Q16 operands fit.
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;

  // Width of the signed delay sum before clamping.
  localparam int DSUM_W = 18;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX       = 4'd3;

  // Configuration register set as seen by the datapath.
  typedef struct packed {
    logic        [7:0]  depth;
    logic        [15:0] mod_depth;
    logic        [15:0] spread;
    logic signed [15:0] mix;
  } cfg_regs_t;

  // Rounded Q15 x Q16 product: floor((p + 2^15) / 2^16). The operand ranges
  // keep the result inside 16 signed bits.
  function automatic logic signed [SAMPLE_W-1:0] mulq_rnd(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + PROD_W'(32768);
    return s[31:16];
  endfunction

  // Saturate a 17-bit signed sum to the Q15 range.
  function automatic logic signed [SAMPLE_W-1:0] sat17(input logic signed [16:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Dry plus twice the wet product, rounded to Q15 and saturated.
  function automatic logic signed [SAMPLE_W-1:0] mix_round(
    input logic signed [SAMPLE_W-1:0] dry,
    input logic signed [PROD_W-1:0]   p
  );
    logic signed [PROD_W+1:0]  dry_term;
    logic signed [PROD_W+1:0]  wet_term;
    logic signed [PROD_W+1:0]  acc;
    logic signed [PROD_W-15:0] q;
    logic signed [SAMPLE_W-1:0] r;
    dry_term = $signed({{(PROD_W-30){dry[15]}}, dry, 16'h0000});
    wet_term = $signed({p[PROD_W-1], p, 1'b0});
    acc      = dry_term + wet_term + (PROD_W+2)'(32768);
    q        = acc[PROD_W+1:16];
    if (q > (PROD_W-14)'(32767)) begin
      r = 16'sh7FFF;
    end else if (q < (PROD_W-14)'(-32768)) begin
      r = 16'sh8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

endpackage

// ----- design/scd_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module scd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/scd_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on scd_pkg for the operand and product widths.
module scd_mul import scd_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- design/scd_cfg.sv -----
// Configuration register file of the stereo chorus.
// Depends on scd_pkg for the register indexes and the register set type.
module scd_cfg import scd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_regs_t             regs
);

  // Register writes; indexes outside the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en) begin
      unique case (index)
        REG_DEPTH:     regs.depth     <= data[7:0];
        REG_MOD_DEPTH: regs.mod_depth <= data;
        REG_SPREAD:    regs.spread    <= data;
        REG_MIX:       regs.mix       <= $signed(data);
        default: ;
      endcase
    end
  end

endmodule

// ----- design/stereo_modulated_delay_chorus_unit.sv -----
// Stereo chorus: each stereo sample passes through S_IDLE, S_RD, S_MX, S_MY,
// S_MZ and S_OUT, and on the first sample of each block also through S_P0 to
// S_P9, where the two channel delays are recomputed through ten extra
// sequencer steps that make six passes of the one shared 17x17 multiplier;
// the mix stage also uses that multiplier, once per channel. A result is
// loaded into the output register in S_OUT, and the unit is ready again in the
// following cycle. A new sample is accepted while a finished result still
// waits in the output register, but the next result is only loaded once that
// one has been taken, and the input stays blocked until then. Each channel
// keeps its history in a ring RAM of BLOCK_SAMPLES << BLOCK_COUNT_LOG2
// samples; ring positions not yet written since reset read as zero, tracked by
// the fill position, so no clearing pass is needed after reset.
// Depends on scd_pkg, scd_cfg, scd_mul and scd_ram.
module stereo_modulated_delay_chorus_unit import scd_pkg::*; #(
  parameter int BLOCK_SAMPLES    = 96,
  parameter int BLOCK_COUNT_LOG2 = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream. s_tdata: left_in [15:0], right_in [31:16], mod_value [47:32].
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,
  // Output stream. m_tdata: left_out [15:0], right_out [31:16].
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RING_SIZE   = BLOCK_SAMPLES << BLOCK_COUNT_LOG2;
  localparam int ADDR_W      = $clog2(RING_SIZE);
  localparam int SIB_W       = $clog2(BLOCK_SAMPLES);
  localparam int DEPTH_SCALE = BLOCK_SAMPLES >> (9 - BLOCK_COUNT_LOG2);
  localparam int DELAY_TOP   = RING_SIZE - BLOCK_SAMPLES;

  typedef enum logic [4:0] {
    S_IDLE,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
    S_RD, S_MX, S_MY, S_MZ, S_OUT
  } state_t;

  state_t state;

  cfg_regs_t cfg;

  // Item registers.
  logic signed [SAMPLE_W-1:0] dry_l, dry_r, lfo;
  // Delay computation registers.
  logic signed [SAMPLE_W-1:0] diff, comm, mod_l, mod_r, t_l, t_r;
  logic signed [DSUM_W-1:0]   dsum_l, dsum_r;
  logic [ADDR_W-1:0]          delay_left, delay_right;
  // Ring position tracking.
  logic [ADDR_W-1:0]          wr_addr;
  logic [SIB_W-1:0]           sample_cnt;
  logic                       wrapped;
  logic                       hit_l, hit_r, bypass_l, bypass_r;
  logic signed [SAMPLE_W-1:0] res_l, res_r;

  // Shared multiplier operands and product.
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] mul_res;

  logic [15:0]                d_samp;
  logic [ADDR_W:0]            rdiff_l, rdiff_r;
  logic [ADDR_W-1:0]          rd_l, rd_r;
  logic [SAMPLE_W-1:0]        ram_l_q, ram_r_q;
  logic signed [SAMPLE_W-1:0] wet_l, wet_r;
  logic                       ring_we;

  // Clamp a delay sum into 0 .. ring size minus one block.
  function automatic logic [ADDR_W-1:0] clamp_delay(input logic signed [DSUM_W-1:0] s);
    logic [ADDR_W-1:0] r;
    if (s < 0) begin
      r = '0;
    end else if (s > DSUM_W'(DELAY_TOP)) begin
      r = ADDR_W'(DELAY_TOP);
    end else begin
      r = s[ADDR_W-1:0];
    end
    return r;
  endfunction

  scd_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .regs  (cfg)
  );

  scd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  scd_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_SIZE)) u_ring_l (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wr_addr),
    .wdata (dry_l),
    .raddr (rd_l),
    .rdata (ram_l_q)
  );

  scd_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_SIZE)) u_ring_r (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wr_addr),
    .wdata (dry_r),
    .raddr (rd_r),
    .rdata (ram_r_q)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign ring_we   = (state == S_RD);

  // Base delay in samples.
  assign d_samp  = 16'(32'(cfg.depth) * 32'(DEPTH_SCALE));
  assign mul_res = mulq_rnd(prod);

  // Read positions a delay behind the write position, modulo the ring size.
  assign rdiff_l = {1'b0, wr_addr} - {1'b0, delay_left};
  assign rdiff_r = {1'b0, wr_addr} - {1'b0, delay_right};
  assign rd_l = rdiff_l[ADDR_W] ? ADDR_W'(rdiff_l + (ADDR_W+1)'(RING_SIZE))
                                : rdiff_l[ADDR_W-1:0];
  assign rd_r = rdiff_r[ADDR_W] ? ADDR_W'(rdiff_r + (ADDR_W+1)'(RING_SIZE))
                                : rdiff_r[ADDR_W-1:0];

  // Wet samples: the current sample at zero delay, zero where never written.
  assign wet_l = bypass_l ? dry_l : (hit_l ? $signed(ram_l_q) : '0);
  assign wet_r = bypass_r ? dry_r : (hit_r ? $signed(ram_r_q) : '0);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_P0: begin
        mul_a = MUL_W'(lfo);
        mul_b = $signed({1'b0, cfg.spread});
      end
      S_P1: begin
        mul_a = MUL_W'(lfo);
        mul_b = $signed({1'b0, ~cfg.spread});
      end
      S_P4: begin
        mul_a = MUL_W'(mod_l);
        mul_b = $signed({1'b0, cfg.mod_depth});
      end
      S_P5: begin
        mul_a = MUL_W'(mod_r);
        mul_b = $signed({1'b0, cfg.mod_depth});
      end
      S_P6: begin
        mul_a = MUL_W'(t_l);
        mul_b = $signed({1'b0, d_samp});
      end
      S_P7: begin
        mul_a = MUL_W'(t_r);
        mul_b = $signed({1'b0, d_samp});
      end
      S_MX: begin
        mul_a = MUL_W'(wet_l);
        mul_b = MUL_W'(cfg.mix);
      end
      S_MY: begin
        mul_a = MUL_W'(wet_r);
        mul_b = MUL_W'(cfg.mix);
      end
      default: ;
    endcase
  end

  // Sequencer, datapath registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      wr_addr     <= '0;
      sample_cnt  <= '0;
      wrapped     <= 1'b0;
      delay_left  <= '0;
      delay_right <= '0;
    end else begin
      // A taken result frees the output register, unless S_OUT refills it now.
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            dry_l <= $signed(s_tdata[15:0]);
            dry_r <= $signed(s_tdata[31:16]);
            lfo   <= $signed(s_tdata[47:32]);
            state <= (sample_cnt == '0) ? S_P0 : S_RD;
          end
        end
        // Block start: recompute both channel delays.
        S_P0: state <= S_P1;
        S_P1: begin
          diff  <= mul_res;
          state <= S_P2;
        end
        S_P2: begin
          comm  <= mul_res;
          state <= S_P3;
        end
        S_P3: begin
          mod_l <= sat17($signed({comm[15], comm}) + $signed({diff[15], diff}));
          mod_r <= sat17($signed({comm[15], comm}) - $signed({diff[15], diff}));
          state <= S_P4;
        end
        S_P4: state <= S_P5;
        S_P5: begin
          t_l   <= mul_res;
          state <= S_P6;
        end
        S_P6: begin
          t_r   <= mul_res;
          state <= S_P7;
        end
        S_P7: begin
          dsum_l <= $signed({2'b00, d_samp}) + DSUM_W'(mul_res);
          state  <= S_P8;
        end
        S_P8: begin
          dsum_r <= $signed({2'b00, d_samp}) + DSUM_W'(mul_res);
          state  <= S_P9;
        end
        S_P9: begin
          delay_left  <= clamp_delay(dsum_l);
          delay_right <= clamp_delay(dsum_r);
          state       <= S_RD;
        end
        // Ring write and delayed read issue.
        S_RD: begin
          hit_l    <= wrapped || (rd_l < wr_addr);
          hit_r    <= wrapped || (rd_r < wr_addr);
          bypass_l <= (delay_left == '0);
          bypass_r <= (delay_right == '0);
          state    <= S_MX;
        end
        S_MX: state <= S_MY;
        S_MY: begin
          res_l <= mix_round(dry_l, prod);
          state <= S_MZ;
        end
        S_MZ: begin
          res_r <= mix_round(dry_r, prod);
          state <= S_OUT;
        end
        // Load the result once the output register is free.
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {res_r, res_l};
            m_tvalid <= 1'b1;
            if (wr_addr == ADDR_W'(RING_SIZE - 1)) begin
              wr_addr <= '0;
              wrapped <= 1'b1;
            end else begin
              wr_addr <= wr_addr + 1'b1;
            end
            if (sample_cnt == SIB_W'(BLOCK_SAMPLES - 1)) begin
              sample_cnt <= '0;
            end else begin
              sample_cnt <= sample_cnt + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/scd_chk.sv -----
// Port-level checker for the stereo chorus, bound to the top level.
// Depends only on the top level's ports.
module scd_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // After reset no result is pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending right after reset");

  // After reset the block is ready for a sample.
  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("not ready right after reset");

  // An accepted sample keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready again right after an input transaction");

  // A new result appears only at the end of a sample's processing.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while the block was idle");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output transaction changed");

endmodule

bind stereo_modulated_delay_chorus_unit scd_chk u_scd_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
